[hw/rtl/smp_pkg.sv]
// shared constants, types and register codes for the substring match block
// no dependencies
package smp_pkg;

    localparam int PATTERN_MAX  = 16;
    localparam int WINDOW_DEPTH = PATTERN_MAX - 1;
    localparam int TEXT_MAX     = 65536;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 5;
    localparam int PIDX_W       = $clog2(PATTERN_MAX);
    localparam int INDEX_W      = 17;
    localparam int POS_W        = 16;
    localparam int TOTAL_W      = 17;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_ADDR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = FIFO_ADDR_W + 1;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(1);
    localparam logic [INDEX_W-1:0] INDEX_CAP = INDEX_W'(TEXT_MAX);
    localparam logic [TOTAL_W-1:0] COUNT_CAP = TOTAL_W'(TEXT_MAX);
    localparam logic [INDEX_W-1:0] POS_CAP   = INDEX_W'(2 ** POS_W - 1);

    typedef logic [WINDOW_DEPTH-1:0][BYTE_W-1:0] t_window;
    typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0]  t_pattern;

    typedef struct packed {
        logic               match_found;
        logic [POS_W-1:0]   match_position;
        logic [TOTAL_W-1:0] match_total;
        logic               text_done;
    } t_result;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] position;
    } t_match;

endpackage

[hw/rtl/smp_in_if.sv]
// input channel: one text byte per item with a last-byte mark
// depends on smp_pkg
interface smp_in_if;
    import smp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

[hw/rtl/smp_out_if.sv]
// result channel: match positions and end-of-text totals
// depends on smp_pkg
interface smp_out_if;
    import smp_pkg::*;

    logic               valid;
    logic               ready;
    logic               match_found;
    logic [POS_W-1:0]   match_position;
    logic [TOTAL_W-1:0] match_total;
    logic               text_done;

    modport source (output valid, output match_found, output match_position,
                    output match_total, output text_done, input ready);
    modport sink   (input valid, input match_found, input match_position,
                    input match_total, input text_done, output ready);
endinterface

[hw/rtl/smp_matcher.sv]
// window compare: checks whether the recent bytes plus the new byte end with the pattern
// depends on smp_pkg
module smp_matcher (
    input  logic [smp_pkg::BYTE_W-1:0]  i_text_byte,
    input  smp_pkg::t_window            i_window,
    input  smp_pkg::t_pattern           i_pattern,
    input  logic [smp_pkg::LEN_W-1:0]   i_pattern_length,
    input  logic [smp_pkg::INDEX_W-1:0] i_byte_index,
    output smp_pkg::t_match             o_match
);
    import smp_pkg::*;

    logic [LEN_W-1:0]                len_c;
    logic [PIDX_W-1:0]               len_m1;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] wv;
    logic [PATTERN_MAX-1:0]          eq;
    logic                            enough;
    logic [INDEX_W-1:0]              pos_full;

    assign len_c  = (i_pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                             : i_pattern_length;
    assign len_m1 = PIDX_W'(len_c - LEN_W'(1));
    assign wv     = {i_window, i_text_byte};

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            eq[k] = (LEN_W'(k) >= len_c)
                 || (wv[k] == i_pattern[PIDX_W'(len_m1 - PIDX_W'(k))]);
        end
    end

    assign enough   = (i_byte_index >= (INDEX_W'(len_c) - INDEX_W'(1)));
    assign pos_full = i_byte_index - (INDEX_W'(len_c) - INDEX_W'(1));

    assign o_match.hit      = (len_c != '0) && enough && (&eq);
    assign o_match.position = (pos_full > POS_CAP) ? POS_CAP[POS_W-1:0]
                                                   : pos_full[POS_W-1:0];
endmodule

[hw/rtl/smp_result_fifo.sv]
// small result queue: takes up to two items per cycle, hands out one
// depends on smp_pkg
module smp_result_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  smp_pkg::t_result    i_item0,
    input  smp_pkg::t_result    i_item1,
    output logic                o_room,
    output logic                o_valid,
    output smp_pkg::t_result    o_item,
    input  logic                i_pop
);
    import smp_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_ADDR_W-1:0] r_wp;
    logic [FIFO_ADDR_W-1:0] r_rp;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic [FIFO_ADDR_W-1:0] wp1;
    logic                   pop;

    assign wp1     = r_wp + FIFO_ADDR_W'(1);
    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rp];
    assign o_room  = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_item0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wp1] <= i_item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + FIFO_ADDR_W'(i_push_cnt);
            r_rp    <= r_rp + FIFO_ADDR_W'(pop);
            r_count <= r_count + FIFO_CNT_W'(i_push_cnt) - FIFO_CNT_W'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count above depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> o_room)
        else $error("push into result queue without room");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt == 2'd0 && !pop) |=> $stable(r_count))
        else $error("result queue count moved without push or pop");
endmodule

[hw/rtl/substring_match_positions_core.sv]
// top level of the streaming substring search: state, config and result queue
// depends on smp_pkg, smp_in_if, smp_out_if, smp_matcher, smp_result_fifo
//
// usage
//   i_text carries one text byte per item, final_byte marks the last byte of a text.
//   o_result carries match items (match_found set, start position and running total)
//   and, after the last byte, one done item (text_done set, total matches).
//   the pattern (up to 16 bytes) and its length are written on the config port
//   (index 0: bytes 0-7, index 1: bytes 8-15, index 2: length) while idle.
// result timing and throughput
//   an accepted byte is compared against the window in the cycle it is taken; its
//   results sit in the result queue from the next cycle on.
//   one byte is taken per cycle while the queue has room; a byte that yields a match
//   and a done item puts two items in the queue, and the single output side then sets
//   the pace to one result item per cycle.
// reset and stalls
//   reset clears the window, byte index, match count and queue; length reads 1.
//   when the receiver stalls, up to four result items queue up; the input drops
//   ready once fewer than two slots are free.
module substring_match_positions_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    smp_in_if.sink                            i_text,
    smp_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [smp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [smp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import smp_pkg::*;

    logic [CFG_DATA_W-1:0] r_pattern_low;
    logic [CFG_DATA_W-1:0] r_pattern_high;
    logic [LEN_W-1:0]      r_pattern_length;

    t_window               r_window;
    logic [INDEX_W-1:0]    r_byte_index;
    logic [TOTAL_W-1:0]    r_found_count;

    t_window               n_window;
    logic [INDEX_W-1:0]    n_byte_index;
    logic [TOTAL_W-1:0]    n_found_count;

    t_match                match;
    t_result               match_item;
    t_result               done_item;
    t_result               item0;
    t_result               head;
    logic                  accept;
    logic                  hit;
    logic                  room;
    logic                  q_valid;
    logic [1:0]            push_cnt;
    logic [TOTAL_W-1:0]    count_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_pattern_length <= LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_LOW:  r_pattern_low    <= i_cfg_data;
                REG_PATTERN_HIGH: r_pattern_high   <= i_cfg_data;
                REG_PATTERN_LEN:  r_pattern_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    smp_matcher u_matcher (
        .i_text_byte      (i_text.text_byte),
        .i_window         (r_window),
        .i_pattern        ({r_pattern_high, r_pattern_low}),
        .i_pattern_length (r_pattern_length),
        .i_byte_index     (r_byte_index),
        .o_match          (match)
    );

    assign accept = i_text.valid && i_text.ready;
    assign hit    = match.hit;

    assign count_upd = (hit && (r_found_count < COUNT_CAP))
                     ? r_found_count + TOTAL_W'(1) : r_found_count;

    always_comb begin
        match_item.match_found    = 1'b1;
        match_item.match_position = match.position;
        match_item.match_total    = count_upd;
        match_item.text_done      = 1'b0;
        done_item.match_found     = 1'b0;
        done_item.match_position  = '0;
        done_item.match_total     = count_upd;
        done_item.text_done       = 1'b1;
        item0    = hit ? match_item : done_item;
        push_cnt = accept ? (2'(hit) + 2'(i_text.final_byte)) : 2'd0;
    end

    always_comb begin
        n_window      = r_window;
        n_byte_index  = r_byte_index;
        n_found_count = r_found_count;
        if (accept) begin
            if (i_text.final_byte) begin
                n_window      = '0;
                n_byte_index  = '0;
                n_found_count = '0;
            end else begin
                n_window      = {r_window[WINDOW_DEPTH-2:0], i_text.text_byte};
                n_byte_index  = (r_byte_index < INDEX_CAP)
                              ? r_byte_index + INDEX_W'(1) : r_byte_index;
                n_found_count = count_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= '0;
            r_byte_index  <= '0;
            r_found_count <= '0;
        end else begin
            r_window      <= n_window;
            r_byte_index  <= n_byte_index;
            r_found_count <= n_found_count;
        end
    end

    smp_result_fifo u_result_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_item0    (item0),
        .i_item1    (done_item),
        .o_room     (room),
        .o_valid    (q_valid),
        .o_item     (head),
        .i_pop      (o_result.ready)
    );

    assign i_text.ready            = room;
    assign o_result.valid          = q_valid;
    assign o_result.match_found    = head.match_found;
    assign o_result.match_position = head.match_position;
    assign o_result.match_total    = head.match_total;
    assign o_result.text_done      = head.text_done;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_text.final_byte) |=> (r_byte_index == '0 && r_found_count == '0))
        else $error("text state not cleared after last byte");

    a_index_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= INDEX_CAP && r_found_count <= COUNT_CAP)
        else $error("byte index or match count beyond cap");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> ($stable(r_byte_index) && $stable(r_found_count)))
        else $error("text state moved without an accepted item");

    a_count_vs_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        TOTAL_W'(r_found_count) <= r_byte_index)
        else $error("more matches than bytes taken");
endmodule

[sim/smp_search_checker.sv]
`timescale 1ns / 1ps
// checker for the substring match block: watches the text, result and config ports,
// keeps its own copy of the search state and compares every result item in order
// depends on smp_pkg, smp_in_if, smp_out_if
module smp_search_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    smp_in_if                               text_ch,
    smp_out_if                              res_ch,
    input  logic                            i_cfg_we,
    input  logic [smp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [smp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import smp_pkg::*;

    localparam int REPORT_MAX = 40;

    t_pattern           pat;
    logic [LEN_W-1:0]   pat_len;
    logic [BYTE_W-1:0]  recent [WINDOW_DEPTH];
    logic [INDEX_W-1:0] seen;
    logic [TOTAL_W-1:0] found;
    t_result            due_results [$];
    int                 fails = 0;

    task automatic report_mismatch(input string msg);
        if (fails < REPORT_MAX) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        fails++;
    endtask

    function automatic void clear_text();
        foreach (recent[k]) recent[k] = '0;
        seen  = '0;
        found = '0;
    endfunction

    task automatic scan_text_byte(input logic [BYTE_W-1:0] b, input logic last);
        int      span;
        int      start;
        logic    hit;
        t_result r;
        span = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
        if (span > 0 && int'(seen) >= span - 1) begin
            hit = (pat[span-1] == b);
            for (int k = 1; k < span; k++) begin
                if (pat[span-1-k] != recent[k-1]) hit = 1'b0;
            end
            if (hit) begin
                start = int'(seen) - (span - 1);
                if (start > TEXT_MAX - 1) start = TEXT_MAX - 1;
                if (start > 2 ** POS_W - 1) start = 2 ** POS_W - 1;
                if (found < COUNT_CAP && found != '1) found = found + 1'b1;
                r = '{match_found: 1'b1, match_position: start[POS_W-1:0],
                      match_total: found, text_done: 1'b0};
                due_results.push_back(r);
            end
        end
        for (int k = WINDOW_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = b;
        if (seen < INDEX_CAP) seen = seen + 1'b1;
        if (last) begin
            r = '{match_found: 1'b0, match_position: '0, match_total: found, text_done: 1'b1};
            due_results.push_back(r);
            clear_text();
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("result with none due: found %0b pos %0d total %0d done %0b",
                got.match_found, got.match_position, got.match_total, got.text_done));
        end else begin
            want = due_results.pop_front();
            if (got.match_found != want.match_found)
                report_mismatch($sformatf("match_found got %0b expected %0b",
                    got.match_found, want.match_found));
            if (got.match_position != want.match_position)
                report_mismatch($sformatf("match_position got %0d expected %0d",
                    got.match_position, want.match_position));
            if (got.match_total != want.match_total)
                report_mismatch($sformatf("match_total got %0d expected %0d",
                    got.match_total, want.match_total));
            if (got.text_done != want.text_done)
                report_mismatch($sformatf("text_done got %0b expected %0b",
                    got.text_done, want.text_done));
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            pat     = '0;
            pat_len = LEN_RESET;
            clear_text();
            due_results.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = '{match_found: res_ch.match_found, match_position: res_ch.match_position,
                        match_total: res_ch.match_total, text_done: res_ch.text_done};
                check_result(got);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATTERN_LOW:  pat[7:0]  = i_cfg_data;
                    REG_PATTERN_HIGH: pat[15:8] = i_cfg_data;
                    REG_PATTERN_LEN:  pat_len   = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (text_ch.valid && text_ch.ready) begin
                scan_text_byte(text_ch.text_byte, text_ch.final_byte);
            end
        end
        o_pending    = due_results.size();
        o_fail_count = fails;
    end

endmodule

[sim/substring_match_positions_core_test.sv]
`timescale 1ns / 1ps
// top of the substring match testbench: clock, reset, text stimulus, result sink and verdict
// depends on smp_pkg, smp_in_if, smp_out_if, substring_match_positions_core, smp_search_checker
module substring_match_positions_core_test;
    import smp_pkg::*;

    localparam int GAP_MAX        = 18;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 28;
    localparam int PRESSURE_PHASE = 4;
    localparam int unsigned PHASE_LENS [PHASES] =
        '{1, 16, 0, 16, 31, 17, 2, 16, 3, 5, 8, 16, 4, 12};
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bit   tx_gaps;
    bit   rx_stalls;
    logic rx_hold_start = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;

    t_pattern          pat;
    int unsigned       pat_span;
    logic [BYTE_W-1:0] text_buf [$];

    smp_in_if  text_ch ();
    smp_out_if res_ch ();

    substring_match_positions_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (text_ch),
        .o_result    (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    smp_search_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .text_ch      (text_ch),
        .res_ch       (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result sink: random stalls per item, plus one long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        bit          hold_taken;
        stall_left   = 0;
        hold_left    = 0;
        hold_taken   = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_start && !hold_taken) begin
                hold_left  = RX_HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left != 0) begin
                res_ch.ready = 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                res_ch.ready = 1'b0;
                stall_left--;
            end else begin
                res_ch.ready = 1'b1;
            end
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready && rx_stalls) stall_left = $urandom_range(0, GAP_MAX);
        end
    end

    always @(posedge i_clk) begin
        if ((text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, GAP_MAX) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            text_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        text_ch.valid      = 1'b1;
        text_ch.text_byte  = b;
        text_ch.final_byte = last;
        do @(posedge i_clk); while (!text_ch.ready);
    endtask

    task automatic send_text();
        foreach (text_buf[i]) offer_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    // wait for every due result, then let any byte still in flight drain
    task automatic settle();
        @(negedge i_clk);
        text_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_pattern(input t_pattern p, input int unsigned len);
        logic [CFG_DATA_W-1:0] len_word;
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = LEN_W'(len);
        pat      = p;
        pat_span = (len > PATTERN_MAX) ? PATTERN_MAX : len;
        write_reg(REG_PATTERN_LOW, p[7:0]);
        write_reg(REG_PATTERN_HIGH, p[15:8]);
        write_reg(REG_PATTERN_LEN, len_word);
    endtask

    // whole occurrences, cut-off prefixes, pattern letters and the odd random byte
    task automatic build_text();
        int unsigned target;
        int unsigned part;
        text_buf.delete();
        target = $urandom_range(1, 2 * pat_span + 12);
        while (text_buf.size() < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    for (int j = 0; j < pat_span; j++) text_buf.push_back(pat[j]);
                end
                4, 5: begin
                    part = $urandom_range(0, pat_span);
                    for (int j = 0; j < part; j++) text_buf.push_back(pat[j]);
                end
                6, 7, 8: text_buf.push_back(pat[$urandom_range(0, PATTERN_MAX - 1)]);
                default: text_buf.push_back(BYTE_W'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin : stimulus
        t_pattern p;
        int       sent;
        text_ch.valid      = 1'b0;
        text_ch.text_byte  = '0;
        text_ch.final_byte = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_PATTERN_LOW;
        cfg_data  = '0;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        pat       = '0;
        pat_span  = 1;
        i_rst_n   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset pattern: one zero byte
        text_buf = '{8'h00, 8'hFF, 8'h00};
        send_text();

        // overlapping occurrences, then a text shorter than the pattern
        settle();
        load_pattern(t_pattern'(128'h616261), 3);
        text_buf = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
        send_text();
        text_buf = '{8'h61};
        send_text();

        // empty pattern
        settle();
        load_pattern(t_pattern'(128'h61), 0);
        text_buf = '{8'h61, 8'h61};
        send_text();

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase % 4)
                1: p = {$urandom, $urandom, $urandom, $urandom};
                3: p = (phase == 3) ? '1 : '0;
                default: begin
                    for (int j = 0; j < PATTERN_MAX; j++) p[j] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
                end
            endcase
            if (phase == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
            load_pattern(p, PHASE_LENS[phase]);
            tx_gaps   = (phase % 4 == 1) || (phase % 4 == 2);
            rx_stalls = (phase % 4 == 1) || (phase % 4 == 3);
            // sink holds off while the sender keeps offering items
            if (phase == PRESSURE_PHASE) rx_hold_start = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_text();
                sent += text_buf.size();
                send_text();
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/smp_pkg.sv
hw/rtl/smp_in_if.sv
hw/rtl/smp_out_if.sv
hw/rtl/smp_matcher.sv
hw/rtl/smp_result_fifo.sv
hw/rtl/substring_match_positions_core.sv
sim/smp_search_checker.sv
sim/substring_match_positions_core_test.sv
